// ===== hdl/spi_pkg.sv =====
// Shared types and constants for the sample playback interpolator.
// No dependencies; imported by every module of the block.
package spi_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int SPEED_W    = 20;
	localparam int COUNT_W    = 17;
	localparam int INDEX_W    = 16;
	localparam int WADDR_W    = 16;
	localparam int ACTION_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	// 1.0 samples per tick in Q3.16
	localparam logic [SPEED_W-1:0] SPEED_RESET = 20'h10000;

	typedef enum logic [ACTION_W-1:0] {
		ACT_WRITE  = 3'd0,
		ACT_START  = 3'd1,
		ACT_STOP   = 3'd2,
		ACT_PAUSE  = 3'd3,
		ACT_RESUME = 3'd4,
		ACT_TICK   = 3'd5
	} action_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED = 2'd0,
		REG_COUNT = 2'd1,
		REG_LOOP  = 2'd2
	} cfg_reg_t;

	// status carried alongside each word down the pipeline
	typedef struct packed {
		logic               live;
		logic               playing;
		logic               paused;
		logic [INDEX_W-1:0] index;
	} status_t;

endpackage

// ===== hdl/sample_playback_interpolator_top.sv =====
// Top level of the sample playback interpolator.
// Depends on spi_pkg, spi_ctrl, spi_mem and spi_interp.
// Usage:
//  - Input channel (in_valid / in_stall): one word per action: write a sample,
//    start, stop, pause, resume or tick. Every accepted word gives exactly one
//    result word on the output channel (out_valid / out_stall), in order.
//  - Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): speed (Q3.16,
//    signed), sample count and loop enable. cfg_ready is always high; write only
//    while no word is in flight.
//  - Throughput: one word per clock, any mix of actions, while out_stall does not
//    hold the pipeline. A write is visible to a tick accepted on the very next
//    cycle, since reads and writes of the sample store both happen at the accept edge.
//  - Pipeline: the accept edge registers the sample reads, then the difference,
//    multiply and round into the output register follow, each one registered.
//  - Ticks read two adjacent samples in the same cycle from even and odd banks.
//  - Reset clears the phase, flags, config registers and pipeline valids. The
//    sample store has no reset and no clearing pass; never-written entries read
//    as garbage.
//  - While a result word is held, a stall from the receiver freezes the whole
//    pipeline and raises in_stall in the same cycle; the held word does not change.
module sample_playback_interpolator_top #(
	parameter int SAMPLE_DEPTH = 65536,
	parameter int FRAC_BITS    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [spi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spi_pkg::CFG_DATA_W-1:0] cfg_data,
	// input words
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [spi_pkg::ACTION_W-1:0]   action,
	input  logic [spi_pkg::WADDR_W-1:0]    write_address,
	input  logic [spi_pkg::SAMPLE_W-1:0]   write_sample,
	// result words
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [spi_pkg::SAMPLE_W-1:0]   sample_out,
	output logic                           is_playing,
	output logic                           is_paused,
	output logic [spi_pkg::INDEX_W-1:0]    play_index
);
	import spi_pkg::*;

	localparam int AW  = $clog2(SAMPLE_DEPTH);
	localparam int BAW = (AW > 1) ? AW - 1 : 1;

	logic                adv;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [SAMPLE_W-1:0] mem_wdata;
	logic [BAW-1:0]      even_addr, odd_addr;
	logic [SAMPLE_W-1:0] rd_even_s1, rd_odd_s1;
	logic                v_s1;
	status_t             st_s1;
	logic [FRAC_BITS-1:0] frac_s1;
	logic                lsb_s1;
	logic                clamp_s1;

	// config is always taken
	assign cfg_ready = 1'b1;
	// one stall for the whole pipeline, set by the output register
	assign in_stall  = !adv;

	spi_ctrl #(
		.SAMPLE_DEPTH (SAMPLE_DEPTH),
		.FRAC_BITS    (FRAC_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.action        (action),
		.write_address (write_address),
		.write_sample  (write_sample),
		.adv           (adv),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.even_addr     (even_addr),
		.odd_addr      (odd_addr),
		.v_s1          (v_s1),
		.st_s1         (st_s1),
		.frac_s1       (frac_s1),
		.lsb_s1        (lsb_s1),
		.clamp_s1      (clamp_s1)
	);

	spi_mem #(
		.SAMPLE_DEPTH (SAMPLE_DEPTH)
	) u_mem (
		.clk        (clk),
		.we         (mem_we),
		.waddr      (mem_waddr),
		.wdata      (mem_wdata),
		.adv        (adv),
		.even_addr  (even_addr),
		.odd_addr   (odd_addr),
		.rd_even_s1 (rd_even_s1),
		.rd_odd_s1  (rd_odd_s1)
	);

	spi_interp #(
		.FRAC_BITS (FRAC_BITS)
	) u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.v_s1       (v_s1),
		.st_s1      (st_s1),
		.frac_s1    (frac_s1),
		.lsb_s1     (lsb_s1),
		.clamp_s1   (clamp_s1),
		.rd_even_s1 (rd_even_s1),
		.rd_odd_s1  (rd_odd_s1),
		.out_stall  (out_stall),
		.adv        (adv),
		.out_valid  (out_valid),
		.sample_out (sample_out),
		.is_playing (is_playing),
		.is_paused  (is_paused),
		.play_index (play_index)
	);

endmodule

// ===== hdl/spi_mem.sv =====
// Banked sample store: even and odd sample banks, one write port, one read per bank.
// Depends on spi_pkg.
module spi_mem #(
	parameter int SAMPLE_DEPTH = 65536
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(SAMPLE_DEPTH)-1:0] waddr,
	input  logic [spi_pkg::SAMPLE_W-1:0]  wdata,
	input  logic                          adv,
	input  logic [((($clog2(SAMPLE_DEPTH)) > 1) ? ($clog2(SAMPLE_DEPTH) - 1) : 1)-1:0]
		even_addr,
	input  logic [((($clog2(SAMPLE_DEPTH)) > 1) ? ($clog2(SAMPLE_DEPTH) - 1) : 1)-1:0]
		odd_addr,
	output logic [spi_pkg::SAMPLE_W-1:0]  rd_even_s1,
	output logic [spi_pkg::SAMPLE_W-1:0]  rd_odd_s1
);
	import spi_pkg::*;

	localparam int AW  = $clog2(SAMPLE_DEPTH);
	localparam int BAW = (AW > 1) ? AW - 1 : 1;

	logic [SAMPLE_W-1:0] even_mem [2**BAW];
	logic [SAMPLE_W-1:0] odd_mem  [2**BAW];
	logic [BAW-1:0]      wbank_addr;

	assign wbank_addr = BAW'(waddr >> 1);

	always_ff @(posedge clk) begin
		if (we && !waddr[0]) begin
			even_mem[wbank_addr] <= wdata;
		end
		if (adv) begin
			rd_even_s1 <= even_mem[even_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we && waddr[0]) begin
			odd_mem[wbank_addr] <= wdata;
		end
		if (adv) begin
			rd_odd_s1 <= odd_mem[odd_addr];
		end
	end

endmodule

// ===== hdl/spi_ctrl.sv =====
// Playback control: config registers, phase accumulator, transport flags and
// sample read address generation. Depends on spi_pkg.
module spi_ctrl #(
	parameter int SAMPLE_DEPTH = 65536,
	parameter int FRAC_BITS    = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [spi_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spi_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	input  logic [spi_pkg::ACTION_W-1:0]    action,
	input  logic [spi_pkg::WADDR_W-1:0]     write_address,
	input  logic [spi_pkg::SAMPLE_W-1:0]    write_sample,
	input  logic                            adv,
	output logic                            mem_we,
	output logic [$clog2(SAMPLE_DEPTH)-1:0] mem_waddr,
	output logic [spi_pkg::SAMPLE_W-1:0]    mem_wdata,
	output logic [((($clog2(SAMPLE_DEPTH)) > 1) ? ($clog2(SAMPLE_DEPTH) - 1) : 1)-1:0]
		even_addr,
	output logic [((($clog2(SAMPLE_DEPTH)) > 1) ? ($clog2(SAMPLE_DEPTH) - 1) : 1)-1:0]
		odd_addr,
	output logic                            v_s1,
	output spi_pkg::status_t                st_s1,
	output logic [FRAC_BITS-1:0]            frac_s1,
	output logic                            lsb_s1,
	output logic                            clamp_s1
);
	import spi_pkg::*;

	localparam int AW  = $clog2(SAMPLE_DEPTH);
	localparam int BAW = (AW > 1) ? AW - 1 : 1;
	localparam int CW  = (COUNT_W > AW + 1) ? COUNT_W : AW + 1;
	localparam int PW  = ((AW + FRAC_BITS > SPEED_W) ? AW + FRAC_BITS : SPEED_W) + 2;
	localparam int IW  = PW - FRAC_BITS;
	localparam int XW  = (IW > CW) ? IW : CW;

	localparam logic [PW-1:0] ONE_F   = PW'(1) << FRAC_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(SAMPLE_DEPTH);

	action_t            act;
	logic               accept;

	logic [SPEED_W-1:0] speed_q;
	logic [CW-1:0]      eff_cnt_q;
	logic [CW-1:0]      cnt_m1_q;
	logic               loop_q;
	logic [CW-1:0]      cnt_new;

	logic signed [PW-1:0] phase_q, phase_n;
	logic               playing_q, playing_n;
	logic               paused_q, paused_n;
	logic               live_n;
	logic [INDEX_W-1:0] index_n;

	logic [PW-1:0]      speed_ext;
	logic [PW-1:0]      sum, sum1;
	logic [IW-1:0]      sum_int, sum1_int;
	logic               neg, over, run;
	logic [PW-1:0]      start_phase, low_phase;
	logic [AW-1:0]      idx_rd, idx1_rd;
	logic [AW-1:0]      idx_s1;

	assign act    = action_t'(action);
	assign accept = in_valid && adv;

	// config: count held pre-clamped to the store depth
	assign cnt_new = (CW'(cfg_data[COUNT_W-1:0]) > DEPTH_C) ? DEPTH_C
		: CW'(cfg_data[COUNT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q   <= SPEED_RESET;
			eff_cnt_q <= '0;
			cnt_m1_q  <= '1;
			loop_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SPEED: speed_q <= cfg_data[SPEED_W-1:0];
				REG_COUNT: begin
					eff_cnt_q <= cnt_new;
					cnt_m1_q  <= CW'(cnt_new - 1'b1);
				end
				REG_LOOP:  loop_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// phase step; sum1 is the step plus one sample, for the second read
	assign speed_ext = {{(PW - SPEED_W){speed_q[SPEED_W-1]}}, speed_q};
	assign sum       = phase_q + speed_ext;
	assign sum1      = phase_q + speed_ext + ONE_F;
	assign sum_int   = sum[PW-1:FRAC_BITS];
	assign sum1_int  = sum1[PW-1:FRAC_BITS];
	assign neg       = sum[PW-1];
	assign over      = !neg && (XW'(sum_int) >= XW'(eff_cnt_q));
	assign run       = playing_q && !paused_q && (eff_cnt_q != '0);

	assign start_phase = PW'({eff_cnt_q, {FRAC_BITS{1'b0}}});
	assign low_phase   = PW'({cnt_m1_q, {FRAC_BITS{1'b0}}});

	always_comb begin
		phase_n   = phase_q;
		playing_n = playing_q;
		paused_n  = paused_q;
		live_n    = 1'b0;
		if (accept) begin
			unique case (act)
				ACT_WRITE: begin
				end
				ACT_START: begin
					phase_n   = (!speed_q[SPEED_W-1] && speed_q != '0) ? '0 : start_phase;
					playing_n = 1'b1;
				end
				ACT_STOP: begin
					phase_n   = '0;
					playing_n = 1'b0;
					paused_n  = 1'b0;
				end
				ACT_PAUSE:  paused_n = 1'b1;
				ACT_RESUME: paused_n = 1'b0;
				ACT_TICK: begin
					if (run) begin
						if (neg || over) begin
							if (!loop_q) begin
								playing_n = 1'b0;
								phase_n   = sum;
							end else begin
								phase_n = neg ? low_phase : '0;
								live_n  = 1'b1;
							end
						end else begin
							phase_n = sum;
							live_n  = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign index_n = phase_n[PW-1] ? '0 : INDEX_W'(phase_n[PW-1:FRAC_BITS]);

	// read pair: i and i+1; odd bank always at i/2, even bank steps when i is odd
	always_comb begin
		if (neg) begin
			idx_rd  = AW'(cnt_m1_q);
			idx1_rd = AW'(eff_cnt_q);
		end else if (over) begin
			idx_rd  = '0;
			idx1_rd = AW'(1);
		end else begin
			idx_rd  = AW'(sum_int);
			idx1_rd = AW'(sum1_int);
		end
	end

	assign odd_addr  = BAW'(idx_rd >> 1);
	assign even_addr = idx_rd[0] ? BAW'(idx1_rd >> 1) : BAW'(idx_rd >> 1);

	assign mem_we    = accept && act == ACT_WRITE
		&& (32'(write_address) < 32'(SAMPLE_DEPTH));
	assign mem_waddr = AW'(write_address);
	assign mem_wdata = write_sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			playing_q <= 1'b0;
			paused_q  <= 1'b0;
			v_s1      <= 1'b0;
		end else begin
			phase_q   <= phase_n;
			playing_q <= playing_n;
			paused_q  <= paused_n;
			if (adv) begin
				v_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1   <= '{live: live_n, playing: playing_n, paused: paused_n, index: index_n};
			frac_s1 <= phase_n[FRAC_BITS-1:0];
			lsb_s1  <= idx_rd[0];
			idx_s1  <= idx_rd;
		end
	end

	// last sample: the right-hand neighbour is clamped onto it
	assign clamp_s1 = (CW'(idx_s1) == cnt_m1_q);

	a_live_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		accept && act == ACT_TICK && live_n |->
		!phase_n[PW-1] && (XW'(phase_n[PW-1:FRAC_BITS]) < XW'(eff_cnt_q)))
		else $error("played tick left phase outside the sample range");

	a_stop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && act == ACT_STOP |=> !playing_q && !paused_q && phase_q == '0)
		else $error("stop did not clear transport state");

	a_silent_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && act == ACT_TICK && !run |=> $stable(phase_q))
		else $error("silent tick moved the phase");

	a_write_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> accept && act == ACT_WRITE)
		else $error("sample store written without an accepted write word");

endmodule

// ===== hdl/spi_interp.sv =====
// Interpolation datapath: neighbour select, difference, multiply, round, and the
// output register with its stall control. Depends on spi_pkg.
module spi_interp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          v_s1,
	input  spi_pkg::status_t              st_s1,
	input  logic [FRAC_BITS-1:0]          frac_s1,
	input  logic                          lsb_s1,
	input  logic                          clamp_s1,
	input  logic [spi_pkg::SAMPLE_W-1:0]  rd_even_s1,
	input  logic [spi_pkg::SAMPLE_W-1:0]  rd_odd_s1,
	input  logic                          out_stall,
	output logic                          adv,
	output logic                          out_valid,
	output logic [spi_pkg::SAMPLE_W-1:0]  sample_out,
	output logic                          is_playing,
	output logic                          is_paused,
	output logic [spi_pkg::INDEX_W-1:0]   play_index
);
	import spi_pkg::*;

	localparam int DW  = SAMPLE_W + 1;
	localparam int ACW = SAMPLE_W + FRAC_BITS + 2;
	localparam logic [ACW-1:0] HALF = ACW'(1) << (FRAC_BITS - 1);

	logic [SAMPLE_W-1:0]      a_s1, b_s1;
	logic signed [DW-1:0]     diff_s1;

	logic                     v_s2, v_s3, out_valid_q;
	status_t                  st_s2, st_s3, st_q;
	logic [SAMPLE_W-1:0]      a_s2, a_s3;
	logic signed [DW-1:0]     diff_s2;
	logic [FRAC_BITS-1:0]     frac_s2;
	logic signed [ACW-1:0]    prod_s3;
	logic [ACW-1:0]           acc;
	logic [SAMPLE_W-1:0]      sample_n, sample_q;

	assign adv = !(out_valid_q && out_stall);

	// a = sample at i, b = sample at i+1 (or i again at the last sample)
	assign a_s1    = lsb_s1 ? rd_odd_s1 : rd_even_s1;
	assign b_s1    = clamp_s1 ? a_s1 : (lsb_s1 ? rd_even_s1 : rd_odd_s1);
	assign diff_s1 = $signed({b_s1[SAMPLE_W-1], b_s1}) - $signed({a_s1[SAMPLE_W-1], a_s1});

	// a*(1-f) + b*f == a + (b-a)*f, rounded half up
	assign acc = {{2{a_s3[SAMPLE_W-1]}}, a_s3, {FRAC_BITS{1'b0}}} + ACW'(prod_s3) + HALF;
	assign sample_n = st_s3.live ? acc[FRAC_BITS +: SAMPLE_W] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s2    <= st_s1;
			a_s2     <= a_s1;
			diff_s2  <= diff_s1;
			frac_s2  <= frac_s1;
			st_s3    <= st_s2;
			a_s3     <= a_s2;
			prod_s3  <= diff_s2 * $signed({1'b0, frac_s2});
			st_q     <= st_s3;
			sample_q <= sample_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign sample_out = sample_q;
	assign is_playing = st_q.playing;
	assign is_paused  = st_q.paused;
	assign play_index = st_q.index;

endmodule
